// ===== rtl/core/trmrf_pkg.sv =====
package trmrf_pkg;

  localparam logic [7:0] TOKEN_MARK     = 8'hFF;
  localparam logic [3:0] BROADCAST_ADDR = 4'hF;
  localparam logic [1:0] STATUS_ACK     = 2'h3;
  localparam logic [1:0] STATUS_READ    = 2'h2;

  localparam logic [1:0] ROUTE_TOKEN    = 2'd0;
  localparam logic [1:0] ROUTE_DATABACK = 2'd1;
  localparam logic [1:0] ROUTE_PHY      = 2'd2;

  localparam logic [1:0] REG_OWN_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_CHAT_CONNECTED = 2'd1;
  localparam logic [1:0] REG_CHAT_SAP       = 2'd2;
  localparam logic [1:0] REG_TIME_SAP       = 2'd3;

  localparam logic [8:0] HEADER_LEN = 9'd3;

  typedef struct packed {
    logic [3:0] own_address;
    logic       chat_connected;
    logic [2:0] chat_sap;
    logic [2:0] time_sap;
  } cfg_t;

  typedef struct packed {
    logic       relay_valid;
    logic [1:0] relay_route;
    logic [7:0] relay_byte;
    logic       relay_last;
    logic       ind_valid;
    logic [7:0] ind_byte;
    logic       ind_done;
    logic       ind_accept;
    logic       ind_to_chat;
    logic [3:0] src_address;
    logic [2:0] src_sapi;
  } result_t;

endpackage

// ===== rtl/core/trmrf_cfg.sv =====
module trmrf_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output trmrf_pkg::cfg_t   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address    <= 4'd0;
      cfg.chat_connected <= 1'b0;
      cfg.chat_sap       <= 3'd1;
      cfg.time_sap       <= 3'd3;
    end else if (wr_en) begin
      unique case (reg_sel)
        trmrf_pkg::REG_OWN_ADDRESS:    cfg.own_address    <= pwdata[3:0];
        trmrf_pkg::REG_CHAT_CONNECTED: cfg.chat_connected <= pwdata[0];
        trmrf_pkg::REG_CHAT_SAP:       cfg.chat_sap       <= pwdata[2:0];
        trmrf_pkg::REG_TIME_SAP:       cfg.time_sap       <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      trmrf_pkg::REG_OWN_ADDRESS:    prdata = {28'd0, cfg.own_address};
      trmrf_pkg::REG_CHAT_CONNECTED: prdata = {31'd0, cfg.chat_connected};
      trmrf_pkg::REG_CHAT_SAP:       prdata = {29'd0, cfg.chat_sap};
      trmrf_pkg::REG_TIME_SAP:       prdata = {29'd0, cfg.time_sap};
    endcase
  end

endmodule

// ===== rtl/core/trmrf_filter.sv =====
module trmrf_filter #(
  parameter int TOKEN_LEN = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  trmrf_pkg::cfg_t     cfg,
  output trmrf_pkg::result_t  result
);

  localparam logic [8:0] TOKEN_LAST = 9'(TOKEN_LEN - 1);

  logic       frame_active, frame_active_next;
  logic       is_token, is_token_next;
  logic [8:0] byte_index, byte_index_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] byte_sum, byte_sum_next;
  logic [3:0] source_addr_reg, source_addr_next;
  logic [3:0] dest_addr_reg, dest_addr_next;
  logic [2:0] source_sapi_reg, source_sapi_next;
  logic [2:0] dest_sapi_reg, dest_sapi_next;

  // view of the state with a frame start applied
  logic       act;
  logic       tok;
  logic [8:0] idx;
  logic [7:0] plen;
  logic [7:0] sum;
  logic [3:0] src;
  logic [2:0] src_sapi;
  logic [3:0] dst;
  logic [2:0] dst_sapi;
  logic       upper;
  logic       match;
  logic [1:0] route;
  logic       to_chat;

  always_comb begin
    act      = frame_start | frame_active;
    tok      = frame_start ? (rx_byte == trmrf_pkg::TOKEN_MARK) : is_token;
    idx      = frame_start ? 9'd0 : byte_index;
    plen     = frame_start ? 8'd0 : payload_length;
    sum      = frame_start ? 8'd0 : byte_sum;
    dst      = frame_start ? 4'd0 : dest_addr_reg;
    dst_sapi = frame_start ? 3'd0 : dest_sapi_reg;
    if (frame_start) begin
      src      = tok ? 4'd0 : rx_byte[6:3];
      src_sapi = tok ? 3'd0 : rx_byte[2:0];
    end else begin
      src      = source_addr_reg;
      src_sapi = source_sapi_reg;
    end
    upper   = ((dst == cfg.own_address) || (dst == trmrf_pkg::BROADCAST_ADDR)) &&
              (((dst_sapi == cfg.chat_sap) && cfg.chat_connected) ||
               (dst_sapi == cfg.time_sap));
    match   = (sum[5:0] == rx_byte[7:2]);
    route   = (src == cfg.own_address) ? trmrf_pkg::ROUTE_DATABACK : trmrf_pkg::ROUTE_PHY;
    to_chat = (dst_sapi == cfg.chat_sap);
  end

  always_comb begin
    frame_active_next   = act;
    is_token_next       = tok;
    byte_index_next     = idx;
    payload_length_next = plen;
    byte_sum_next       = sum;
    source_addr_next    = src;
    source_sapi_next    = src_sapi;
    dest_addr_next      = dst;
    dest_sapi_next      = dst_sapi;
    result              = '0;
    if (!act) begin
      frame_active_next   = frame_active;
      is_token_next       = is_token;
      byte_index_next     = byte_index;
      payload_length_next = payload_length;
      byte_sum_next       = byte_sum;
      source_addr_next    = source_addr_reg;
      source_sapi_next    = source_sapi_reg;
      dest_addr_next      = dest_addr_reg;
      dest_sapi_next      = dest_sapi_reg;
    end else if (tok) begin
      result.relay_valid = 1'b1;
      result.relay_route = trmrf_pkg::ROUTE_TOKEN;
      result.relay_byte  = rx_byte;
      if (idx >= TOKEN_LAST) begin
        result.relay_last = 1'b1;
        frame_active_next = 1'b0;
      end else begin
        byte_index_next = idx + 9'd1;
      end
    end else begin
      result.relay_valid = 1'b1;
      result.relay_route = route;
      result.src_address = src;
      result.src_sapi    = src_sapi;
      if (idx < trmrf_pkg::HEADER_LEN) begin
        if (idx == 9'd1) begin
          dest_addr_next = rx_byte[6:3];
          dest_sapi_next = rx_byte[2:0];
        end else if (idx == 9'd2) begin
          payload_length_next = rx_byte;
        end
        byte_sum_next     = sum + rx_byte;
        result.relay_byte = rx_byte;
        byte_index_next   = idx + 9'd1;
      end else if (idx < trmrf_pkg::HEADER_LEN + {1'b0, plen}) begin
        byte_sum_next     = sum + rx_byte;
        result.relay_byte = rx_byte;
        if (upper) begin
          result.ind_valid   = 1'b1;
          result.ind_byte    = rx_byte;
          result.ind_to_chat = to_chat;
        end
        byte_index_next = idx + 9'd1;
      end else begin
        // status byte: read/ack bits
        result.relay_byte = rx_byte;
        if (route == trmrf_pkg::ROUTE_DATABACK) begin
          result.relay_byte[1:0] = rx_byte[1:0] |
            ((match && dst == cfg.own_address) ? trmrf_pkg::STATUS_ACK
                                               : trmrf_pkg::STATUS_READ);
        end else if (dst != trmrf_pkg::BROADCAST_ADDR) begin
          result.relay_byte[1:0] = rx_byte[1:0] |
            (match ? trmrf_pkg::STATUS_ACK : trmrf_pkg::STATUS_READ);
        end
        result.relay_last = 1'b1;
        if (upper) begin
          result.ind_done    = 1'b1;
          result.ind_accept  = match;
          result.ind_to_chat = to_chat;
        end
        frame_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active    <= 1'b0;
      is_token        <= 1'b0;
      byte_index      <= 9'd0;
      payload_length  <= 8'd0;
      byte_sum        <= 8'd0;
      source_addr_reg <= 4'd0;
      source_sapi_reg <= 3'd0;
      dest_addr_reg   <= 4'd0;
      dest_sapi_reg   <= 3'd0;
    end else if (advance) begin
      frame_active    <= frame_active_next;
      is_token        <= is_token_next;
      byte_index      <= byte_index_next;
      payload_length  <= payload_length_next;
      byte_sum        <= byte_sum_next;
      source_addr_reg <= source_addr_next;
      source_sapi_reg <= source_sapi_next;
      dest_addr_reg   <= dest_addr_next;
      dest_sapi_reg   <= dest_sapi_next;
    end
  end

endmodule

// ===== rtl/core/token_ring_mac_receive_filter_top.sv =====
// token ring receive filter
// s_axis carries one received frame byte per request: tdata is the byte,
// tuser is set on the first byte of a frame. every accepted byte gives
// exactly one result request on m_axis, also for idle bytes (all zero).
// the result carries the relayed byte with its route in tuser and the
// frame end in tlast, plus the upward payload stream and the verdict.
// a result becomes valid after its byte is accepted: the byte sits in the
// input register, and the filter logic loads the result register.
// throughput is one byte per cycle while m_axis takes its results; the 8-bit
// sum and 6-bit compare are combinational between the two registers.
// a stalled m_axis keeps its result; the input register still takes one
// more byte, then s_axis_tready drops until the result is taken.
// the apb port holds own address, chat enable, chat and time sapi. the user
// must write it only while no byte is in flight; the block does not enforce it.
// synchronous reset empties both registers, clears the frame state and
// sets the registers to their defaults.
module token_ring_mac_receive_filter_top #(
  parameter int TOKEN_LEN = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // relay_valid, relay_byte, ind_valid, ind_byte, ind_done, ind_accept,
  // ind_to_chat, src_address, src_sapi, zero fill
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // relay_route
  output logic        m_axis_tlast,   // relay_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  trmrf_pkg::cfg_t    cfg;
  trmrf_pkg::result_t result;
  trmrf_pkg::result_t out_reg;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_valid;
  logic       advance;

  assign advance       = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  trmrf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trmrf_filter #(
    .TOKEN_LEN (TOKEN_LEN)
  ) u_filter (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .cfg         (cfg),
    .result      (result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_reg.relay_route;
  assign m_axis_tlast  = out_reg.relay_last;
  assign m_axis_tdata  = {4'd0,
                          out_reg.src_sapi,
                          out_reg.src_address,
                          out_reg.ind_to_chat,
                          out_reg.ind_accept,
                          out_reg.ind_done,
                          out_reg.ind_byte,
                          out_reg.ind_valid,
                          out_reg.relay_byte,
                          out_reg.relay_valid};

endmodule
